// ----- rtl/core/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Element, cofactor and determinant types, divider sizes, status codes and
// the index tables that pick the element pairs for each cofactor.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  // Number of elements in one matrix.
  localparam int NUM_ELEM = 9;

  // Q4.12 element, Q9.24 cofactor, Q13.36 determinant.
  typedef logic signed [15:0] elem_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [32:0] cof_t;
  typedef logic signed [48:0] det_t;

  // Divider sizes: numerator is |cofactor| shifted into Q16.16 position.
  localparam int QUOT_SHIFT = 28;
  localparam int QBITS      = 32;
  localparam int MAG_W      = 33;
  localparam int NUM_W      = MAG_W + QUOT_SHIFT;
  localparam int DEN_W      = 49;
  localparam int CMP_W      = DEN_W + QBITS;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // Saturation limits in Q16.16.
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Adjugate entry k = sign * (m[A]*m[B] - m[C]*m[D]).
  localparam logic [3:0] IDX_A [NUM_ELEM] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam logic [3:0] IDX_B [NUM_ELEM] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam logic [3:0] IDX_C [NUM_ELEM] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
  localparam logic [3:0] IDX_D [NUM_ELEM] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
  localparam logic       NEGATE [NUM_ELEM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // What one divider lane reports to the merging stage.
  typedef struct packed {
    logic [31:0] quot;
    logic        sat;
  } lane_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/matrix3x3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 fixed-point matrix inverse by the adjugate
// Takes a Q4.12 matrix and gives its exact determinant and Q16.16 inverse.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy stays low: the block is fully pipelined and takes a new matrix in
//   every cycle, so the sustained rate is one matrix per clock.
//   Each result appears on out_r00..out_r22, out_det_value and out_status,
//   for exactly one cycle with out_valid high. A request passes through a
//   five-stage cofactor pipeline, then the nine divider lanes, which resolve
//   one quotient bit per stage over 32 stages, and a registered merging stage.
//   The receiver cannot stall the block; results must be taken as they come.
//   out_status is 0 when all is well, 1 for a singular matrix (inverse
//   zeroed) and 2 when some inverse element saturated.
//   A synchronous reset clears the valid pipeline, so no result is issued
//   for requests that were in flight. The data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire signed [15:0]  in_a00,
  input  wire signed [15:0]  in_a01,
  input  wire signed [15:0]  in_a02,
  input  wire signed [15:0]  in_a10,
  input  wire signed [15:0]  in_a11,
  input  wire signed [15:0]  in_a12,
  input  wire signed [15:0]  in_a20,
  input  wire signed [15:0]  in_a21,
  input  wire signed [15:0]  in_a22,
  output logic               out_valid,
  output logic signed [31:0] out_r00,
  output logic signed [31:0] out_r01,
  output logic signed [31:0] out_r02,
  output logic signed [31:0] out_r10,
  output logic signed [31:0] out_r11,
  output logic signed [31:0] out_r12,
  output logic signed [31:0] out_r20,
  output logic signed [31:0] out_r21,
  output logic signed [31:0] out_r22,
  output logic signed [50:0] out_det_value,
  output logic [1:0]         out_status
);

  localparam int LANE_LAT = mi3_pkg::QBITS + 2;

  mi3_pkg::elem_t     m    [mi3_pkg::NUM_ELEM];
  mi3_pkg::cof_t      adj  [mi3_pkg::NUM_ELEM];
  mi3_pkg::det_t      det;
  logic               cof_vld;
  mi3_pkg::lane_out_t lane [mi3_pkg::NUM_ELEM];

  logic [LANE_LAT-1:0] vld_r;
  mi3_pkg::det_t       det_r [LANE_LAT];

  logic               valid_r;
  logic [31:0]        r_r   [mi3_pkg::NUM_ELEM];
  logic [31:0]        r_nxt [mi3_pkg::NUM_ELEM];
  logic signed [50:0] det_out_r;
  logic [1:0]         status_r;
  logic [1:0]         status_nxt;
  logic               singular;
  logic               sat_any;

  assign busy = 1'b0;

  assign m[0] = in_a00;
  assign m[1] = in_a01;
  assign m[2] = in_a02;
  assign m[3] = in_a10;
  assign m[4] = in_a11;
  assign m[5] = in_a12;
  assign m[6] = in_a20;
  assign m[7] = in_a21;
  assign m[8] = in_a22;

  // Cofactors and determinant.
  mi3_cofactor u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .m         (m),
    .out_valid (cof_vld),
    .adj       (adj),
    .det       (det)
  );

  // One divider lane per inverse element.
  for (genvar i = 0; i < mi3_pkg::NUM_ELEM; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk (clk),
      .cof (adj[i]),
      .det (det),
      .res (lane[i])
    );
  end

  // Valid and determinant travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-2:0], cof_vld};
    end
  end

  always_ff @(posedge clk) begin
    det_r[0] <= det;
    for (int s = 1; s < LANE_LAT; s++) begin
      det_r[s] <= det_r[s-1];
    end
  end

  // Merging stage: singular override and the combined saturation flag.
  always_comb begin
    singular = (det_r[LANE_LAT-1] == '0);
    sat_any  = 1'b0;
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
      sat_any  = sat_any | lane[i].sat;
      r_nxt[i] = singular ? 32'd0 : lane[i].quot;
    end
    if (singular) begin
      status_nxt = mi3_pkg::ST_SINGULAR;
    end else if (sat_any) begin
      status_nxt = mi3_pkg::ST_SAT;
    end else begin
      status_nxt = mi3_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    r_r       <= r_nxt;
    det_out_r <= 51'(det_r[LANE_LAT-1]);
    status_r  <= status_nxt;
  end

  assign out_valid     = valid_r;
  assign out_r00       = r_r[0];
  assign out_r01       = r_r[1];
  assign out_r02       = r_r[2];
  assign out_r10       = r_r[3];
  assign out_r11       = r_r[4];
  assign out_r12       = r_r[5];
  assign out_r20       = r_r[6];
  assign out_r21       = r_r[7];
  assign out_r22       = r_r[8];
  assign out_det_value = det_out_r;
  assign out_status    = status_r;

endmodule

`default_nettype wire

// ----- rtl/core/mi3_cofactor.sv -----
// ----------------------------------------------------------------------------
// mi3_cofactor: adjugate and determinant pipeline
// Five register stages: input capture, pair products, cofactors, determinant
// products and the determinant sum. All arithmetic is exact.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_cofactor (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  mi3_pkg::elem_t       m   [mi3_pkg::NUM_ELEM],
  output logic                 out_valid,
  output mi3_pkg::cof_t        adj [mi3_pkg::NUM_ELEM],
  output mi3_pkg::det_t        det
);

  logic [4:0]      vld_r;
  mi3_pkg::elem_t  m_r    [mi3_pkg::NUM_ELEM];
  mi3_pkg::prod_t  pab_r  [mi3_pkg::NUM_ELEM];
  mi3_pkg::prod_t  pcd_r  [mi3_pkg::NUM_ELEM];
  mi3_pkg::elem_t  top2_r [3];
  mi3_pkg::elem_t  top3_r [3];
  mi3_pkg::cof_t   adj3_r [mi3_pkg::NUM_ELEM];
  mi3_pkg::cof_t   adj4_r [mi3_pkg::NUM_ELEM];
  mi3_pkg::cof_t   adj5_r [mi3_pkg::NUM_ELEM];
  mi3_pkg::det_t   dp_r   [3];
  mi3_pkg::det_t   det_r;

  // Valid bits follow the data down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Capture, pair products and cofactors, one lane per adjugate entry.
  for (genvar k = 0; k < mi3_pkg::NUM_ELEM; k++) begin : g_cof
    mi3_pkg::cof_t diff;
    assign diff = mi3_pkg::cof_t'(pab_r[k]) - mi3_pkg::cof_t'(pcd_r[k]);

    always_ff @(posedge clk) begin
      m_r[k]    <= m[k];
      pab_r[k]  <= m_r[mi3_pkg::IDX_A[k]] * m_r[mi3_pkg::IDX_B[k]];
      pcd_r[k]  <= m_r[mi3_pkg::IDX_C[k]] * m_r[mi3_pkg::IDX_D[k]];
      adj3_r[k] <= mi3_pkg::NEGATE[k] ? -diff : diff;
      adj4_r[k] <= adj3_r[k];
      adj5_r[k] <= adj4_r[k];
    end
  end

  // Determinant: first row times the first adjugate column.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      top2_r[j] <= m_r[j];
      top3_r[j] <= top2_r[j];
      dp_r[j]   <= mi3_pkg::det_t'(top3_r[j]) * mi3_pkg::det_t'(adj3_r[3*j]);
    end
  end

  always_ff @(posedge clk) begin
    det_r <= dp_r[0] + dp_r[1] + dp_r[2];
  end

  assign out_valid = vld_r[4];
  assign adj       = adj5_r;
  assign det       = det_r;

endmodule

`default_nettype wire

// ----- rtl/core/mi3_div_lane.sv -----
// ----------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider for one inverse element
// Divides |cofactor| * 2^28 by |determinant|, one quotient bit per stage,
// then applies the sign, truncation toward zero and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane (
  input  wire                  clk,
  input  mi3_pkg::cof_t        cof,
  input  mi3_pkg::det_t        det,
  output mi3_pkg::lane_out_t   res
);

  localparam int QB = mi3_pkg::QBITS;

  logic [mi3_pkg::MAG_W-1:0] cof_mag;
  logic [mi3_pkg::DEN_W-1:0] det_mag;
  logic [mi3_pkg::NUM_W-1:0] num;

  logic [mi3_pkg::NUM_W-1:0] rem_r [QB+1];
  logic [mi3_pkg::DEN_W-1:0] den_r [QB+1];
  logic [QB-1:0]             q_r   [QB+1];
  logic                      neg_r [QB+1];
  logic                      ovf_r [QB+1];

  mi3_pkg::lane_out_t res_r;
  logic [QB-1:0]      q_fin;
  logic               sat_fin;

  // Magnitudes and the early overflow test (quotient of 2^32 or more).
  assign cof_mag = cof[32] ? mi3_pkg::MAG_W'(-cof) : mi3_pkg::MAG_W'(cof);
  assign det_mag = det[48] ? mi3_pkg::DEN_W'(-det) : mi3_pkg::DEN_W'(det);
  assign num     = mi3_pkg::NUM_W'(cof_mag) << mi3_pkg::QUOT_SHIFT;

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= det_mag;
    q_r[0]   <= '0;
    neg_r[0] <= cof[32] ^ det[48];
    ovf_r[0] <= mi3_pkg::CMP_W'(num) >= (mi3_pkg::CMP_W'(det_mag) << QB);
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [mi3_pkg::CMP_W-1:0] dsh;
    logic                      ge;
    assign dsh = mi3_pkg::CMP_W'(den_r[s]) << (QB - 1 - s);
    assign ge  = mi3_pkg::CMP_W'(rem_r[s]) >= dsh;

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? mi3_pkg::NUM_W'(mi3_pkg::CMP_W'(rem_r[s]) - dsh) : rem_r[s];
      q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  // Sign and saturation.
  always_comb begin
    if (neg_r[QB]) begin
      sat_fin = ovf_r[QB] || (q_r[QB] > mi3_pkg::NEG_LIMIT);
      q_fin   = sat_fin ? mi3_pkg::NEG_LIMIT : -q_r[QB];
    end else begin
      sat_fin = ovf_r[QB] || q_r[QB][QB-1];
      q_fin   = sat_fin ? mi3_pkg::POS_LIMIT : q_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    res_r.quot <= q_fin;
    res_r.sat  <= sat_fin;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/mi3_checker.sv -----
// ----------------------------------------------------------------------------
// mi3_checker: port-level checks for the matrix inverse
// Watches the result channel for consistent status, determinant and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire signed [31:0] out_r00,
  input wire signed [31:0] out_r22,
  input wire signed [50:0] out_det_value,
  input wire [1:0]         out_status
);

  // A reset cycle leaves no result behind it.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result issued right after reset");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mi3_pkg::ST_OK || out_status == mi3_pkg::ST_SINGULAR ||
                   out_status == mi3_pkg::ST_SAT))
    else $error("undefined status code");

  // Singular status goes with a zero determinant and zero out_r00 and out_r22.
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mi3_pkg::ST_SINGULAR |->
      out_det_value == '0 && out_r00 == '0 && out_r22 == '0)
    else $error("singular result not zeroed");

  // A zero determinant is always reported as singular.
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_det_value == '0 |-> out_status == mi3_pkg::ST_SINGULAR)
    else $error("zero determinant not flagged");

  // The determinant fits in 49 signed bits.
  a_det_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_det_value[50:48] == 3'b000 || out_det_value[50:48] == 3'b111))
    else $error("determinant out of range");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_r00       (out_r00),
  .out_r22       (out_r22),
  .out_det_value (out_det_value),
  .out_status    (out_status)
);

`default_nettype wire

// ----- dv/tb_matrix3x3_inverse.sv -----
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse: self-checking testbench for the 3x3 matrix inverse
// Drives matrices through the request port, predicts the determinant, inverse
// and status of each one, and checks every result against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_matrix3x3_inverse;

  // One matrix request and one inverse result.
  typedef struct {
    logic signed [15:0] a [9];
  } mat_req_t;

  typedef struct {
    logic signed [31:0] r [9];
    logic signed [50:0] det;
    logic [1:0]         status;
  } inv_res_t;

  // The sender waits for the pipeline to drain after this many requests.
  localparam int DRAIN_AT = 300;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_a [9];
  logic out_valid;
  logic signed [31:0] out_r [9];
  logic signed [50:0] out_det_value;
  logic [1:0] out_status;

  mat_req_t req_queue [$];
  inv_res_t inverse_queue [$];
  int errors;
  int results_seen;
  int singular_seen;
  int sat_seen;
  int sent;
  int gap_cnt;
  mat_req_t cur_req;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid),
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_det_value(out_det_value), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Q9.24 cofactor over Q13.36 determinant, truncated and saturated to Q16.16.
  function automatic logic [31:0] quotient_q16(input longint cof, input longint det,
                                               inout bit sat);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    bit neg;
    num = (cof < 0 ? -cof : cof);
    num = num << 28;
    den = (det < 0 ? -det : det);
    q = num / den;
    neg = (cof < 0) != (det < 0);
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  // Adjugate, determinant and inverse of one matrix.
  function automatic inv_res_t invert_matrix(input mat_req_t m);
    longint e [9];
    longint adj [9];
    longint det;
    bit sat;
    inv_res_t res;
    sat = 1'b0;
    for (int i = 0; i < 9; i++) e[i] = m.a[i];
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = -(e[1] * e[8] - e[2] * e[7]);
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = -(e[3] * e[8] - e[5] * e[6]);
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = -(e[0] * e[5] - e[2] * e[3]);
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = -(e[0] * e[7] - e[1] * e[6]);
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    res.det = 51'(det);
    if (det == 0) begin
      for (int i = 0; i < 9; i++) res.r[i] = '0;
      res.status = mi3_pkg::ST_SINGULAR;
    end else begin
      for (int i = 0; i < 9; i++) res.r[i] = quotient_q16(adj[i], det, sat);
      res.status = sat ? mi3_pkg::ST_SAT : mi3_pkg::ST_OK;
    end
    return res;
  endfunction

  function automatic mat_req_t make_matrix(input int k0, k1, k2, k3, k4, k5, k6, k7, k8);
    mat_req_t m;
    m.a[0] = 16'(k0); m.a[1] = 16'(k1); m.a[2] = 16'(k2);
    m.a[3] = 16'(k3); m.a[4] = 16'(k4); m.a[5] = 16'(k5);
    m.a[6] = 16'(k6); m.a[7] = 16'(k7); m.a[8] = 16'(k8);
    return m;
  endfunction

  // Random element: mostly moderate values, sometimes full range, extremes or tiny values.
  function automatic logic signed [15:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($signed($urandom_range(0, 16383)) - 8192);
    if (sel < 8) return 16'($urandom);
    if (sel == 8) return 16'($urandom_range(0, 1) ? 32767 : -32768);
    return 16'($signed($urandom_range(0, 8)) - 4);
  endfunction

  function automatic mat_req_t rand_matrix();
    mat_req_t m;
    int kind;
    int r0;
    int r1;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 9; i++) m.a[i] = rand_elem();
    if (kind == 0) begin
      // Two equal rows make the matrix singular.
      r0 = $urandom_range(0, 2);
      r1 = (r0 + 1 + $urandom_range(0, 1)) % 3;
      for (int j = 0; j < 3; j++) m.a[r1*3+j] = m.a[r0*3+j];
    end else if (kind == 1) begin
      // Small diagonal gives a huge inverse.
      for (int i = 0; i < 9; i++) m.a[i] = '0;
      for (int i = 0; i < 3; i++) m.a[i*4] = 16'($signed($urandom_range(1, 6)) *
                                            ($urandom_range(0, 1) ? 1 : -1));
    end else if (kind == 2) begin
      // Near-identity matrix with a little noise.
      for (int i = 0; i < 9; i++)
        m.a[i] = 16'((i % 4 == 0 ? 4096 : 0) + $signed($urandom_range(0, 64)) - 32);
    end
    return m;
  endfunction

  // Idle cycles before the next request; every other block of 200 is back to back.
  function automatic int draw_gap(input int n_sent);
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if ((n_sent / 200) % 2 == 1) g = 0;
    return g;
  endfunction

  // Directed matrices, then random ones; reset, then wait for the end.
  initial begin
    errors = 0;
    results_seen = 0;
    singular_seen = 0;
    sat_seen = 0;
    rst_n = 1'b0;
    req_queue.push_back(make_matrix(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
    req_queue.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    req_queue.push_back(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    req_queue.push_back(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    req_queue.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    req_queue.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    req_queue.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
    req_queue.push_back(make_matrix(32767, -32768, 32767, -32768, 32767, -32768,
                                    -32768, 32767, 32767));
    req_queue.push_back(make_matrix(-32768, 32767, 32767, 32767, -32768, 32767,
                                    32767, 32767, -32768));
    req_queue.push_back(make_matrix(0, 4096, 0, 0, 0, 4096, 4096, 0, 0));
    req_queue.push_back(make_matrix(8192, 0, 0, 0, 8192, 0, 0, 0, 8192));
    req_queue.push_back(make_matrix(1, 2, 3, 4, 5, 6, 7, 8, 10));
    req_queue.push_back(make_matrix(1, 2, 3, 4, 5, 6, 7, 8, 9));
    req_queue.push_back(make_matrix(4096, 4096, 0, 0, 4096, 4096, 4096, 0, 4096));
    req_queue.push_back(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    req_queue.push_back(make_matrix(2, 0, 0, 0, 2, 0, 0, 0, 2));
    req_queue.push_back(make_matrix(2, 0, 0, 0, -2, 0, 0, 0, 2));
    req_queue.push_back(make_matrix(0, 0, 1, 0, 1, 0, 1, 0, 0));
    req_queue.push_back(make_matrix(21845, -10923, 5461, -2731, 1365, -683,
                                    341, -171, 85));
    req_queue.push_back(make_matrix(4096, 0, 0, 0, 4096, 0, 0, 0, -32768));
    for (int n = 0; n < 1530; n++) req_queue.push_back(rand_matrix());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (req_queue.size() > 0 || start || inverse_queue.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d matrices with random and back-to-back spacing and one full drain.",
             sent);
    $display("Checked %0d results: %0d singular, %0d saturated.",
             results_seen, singular_seen, sat_seen);
    if (errors == 0) begin
      $display("tb_matrix3x3_inverse: PASS");
    end else begin
      $display("tb_matrix3x3_inverse: FAIL");
    end
    $finish;
  end

  // Driver: requests change at the falling edge, with random gaps.
  always @(negedge clk) begin
    bit accepted;
    accepted = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      for (int i = 0; i < 9; i++) in_a[i] <= '0;
      gap_cnt = 0;
      sent = 0;
    end else begin
      if (accepted) begin
        inverse_queue.push_back(invert_matrix(cur_req));
        sent++;
        gap_cnt = draw_gap(sent);
      end
      if (!start || accepted) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (sent == DRAIN_AT && inverse_queue.size() > 0) begin
          // Let every outstanding request finish before going on.
          start <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          start <= 1'b1;
          for (int i = 0; i < 9; i++) in_a[i] <= cur_req.a[i];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    inv_res_t exp_res;
    if (rst_n && out_valid) begin
      if (inverse_queue.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_res = inverse_queue.pop_front();
        results_seen++;
        if (exp_res.status == mi3_pkg::ST_SINGULAR) singular_seen++;
        if (exp_res.status == mi3_pkg::ST_SAT) sat_seen++;
        for (int i = 0; i < 9; i++) begin
          if (out_r[i] !== exp_res.r[i]) begin
            $error("r%0d%0d: expected %0d, got %0d", i / 3, i % 3, exp_res.r[i], out_r[i]);
            errors++;
          end
        end
        if (out_det_value !== exp_res.det) begin
          $error("det_value: expected %0d, got %0d", exp_res.det, out_det_value);
          errors++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb_matrix3x3_inverse: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
